FILE: design/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands for the matrix multiply block, sampled on clock and
// disabled while reset is high.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define MMDP_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define MMDP_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: design/mmdp_pkg.sv
// ---------------------------------------------------------------------------
// mmdp_pkg
// Shared constants, codes and control types of the matrix multiply block.
// ---------------------------------------------------------------------------
package mmdp_pkg;

   localparam int DIM_DEFAULT = 16;

   localparam int SIZE_W     = 5;
   localparam int IDX_W      = 4;
   localparam int VAL_W      = 32;
   localparam int PROD_W     = 64;
   localparam int MODE_W     = 2;
   localparam int REQ_DATA_W = 40;   // row, col, element_value
   localparam int RSP_DATA_W = 72;   // product_value, row_echo, col_echo

   localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd16;

   localparam logic [MODE_W-1:0] MODE_WR_A = 2'd0;
   localparam logic [MODE_W-1:0] MODE_WR_B = 2'd1;
   localparam logic [MODE_W-1:0] MODE_REQ  = 2'd2;

   // controller to datapath commands
   typedef struct packed {
      logic load;     // latch request indices, clear accumulator
      logic wr_a;     // write element of A from the input beat
      logic wr_b;     // write element of B from the input beat
      logic rd;       // read one element pair at the current index
      logic finish;   // saturate and load the result register
   } mmdp_cmd_type;

endpackage

FILE: design/mmdp_ctrl.sv
// ---------------------------------------------------------------------------
// mmdp_ctrl
// Sequencer: accepts beats, walks the dot-product index and hands the
// finished sum to the result register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module mmdp_ctrl #(
   parameter int DIM = mmdp_pkg::DIM_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_wr_en,
   input  logic [mmdp_pkg::SIZE_W-1:0]        csr_wr_data,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [mmdp_pkg::MODE_W-1:0]        req_mode,
   input  logic [mmdp_pkg::IDX_W-1:0]         req_row,
   input  logic [mmdp_pkg::IDX_W-1:0]         req_col,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   input  logic                               pipe_busy,
   output mmdp_pkg::mmdp_cmd_type             cmd,
   output logic [$clog2(DIM)-1:0]             rd_idx
);
   import mmdp_pkg::*;

   localparam int NW = $clog2(DIM + 1);
   localparam int KW = $clog2(DIM);

   typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DRAIN} state_type;

   state_type           state_ff, state_in;
   logic [SIZE_W-1:0]   size_ff;
   logic [NW-1:0]       n_ff, n_in;
   logic [NW-1:0]       cnt_ff, cnt_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                accept;
   logic                in_range;
   logic [NW-1:0]       n_req;
   logic                out_free;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign in_range   = (32'(req_row) < DIM) && (32'(req_col) < DIM);
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // terms to sum; an index beyond the store gives an empty sum
   always_comb begin
      if (!in_range) begin
         n_req = '0;
      end else if (32'(size_ff) > DIM) begin
         n_req = NW'(DIM);
      end else begin
         n_req = NW'(size_ff);
      end
   end

   always_comb begin
      cmd        = '0;
      cmd.load   = accept && (req_mode == MODE_REQ);
      cmd.wr_a   = accept && (req_mode == MODE_WR_A) && in_range;
      cmd.wr_b   = accept && (req_mode == MODE_WR_B) && in_range;
      cmd.rd     = (state_ff == ST_RUN);
      cmd.finish = (state_ff == ST_DRAIN) && !pipe_busy && out_free;
   end

   assign rd_idx = cnt_ff[KW-1:0];

   always_comb begin
      state_in     = state_ff;
      n_in         = n_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (cmd.load) begin
               n_in     = n_req;
               cnt_in   = '0;
               state_in = (n_req == '0) ? ST_DRAIN : ST_RUN;
            end
         end
         ST_RUN: begin
            cnt_in = NW'(cnt_ff + 1'b1);
            if (cnt_in == n_ff) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (cmd.finish) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         size_ff      <= SIZE_RESET;
         n_ff         <= '0;
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         n_ff         <= n_in;
         cnt_ff       <= cnt_in;
         if (csr_wr_en) begin
            size_ff <= csr_wr_data;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

   `MMDP_ASSERT_IMPL(a_finish_drained, cmd.finish, !pipe_busy && out_free,
      "result taken before the accumulator settled")
   `MMDP_ASSERT_NEXT(a_finish_shows, cmd.finish, rsp_valid_ff,
      "finished result not presented")
   `MMDP_ASSERT_IMPL(a_idx_in_range, cmd.rd, cnt_ff < n_ff,
      "element index walked past the size in use")
   `MMDP_ASSERT_IMPL(a_no_accept_busy, accept, !pipe_busy,
      "beat accepted while element pairs still in flight")

endmodule

FILE: design/mmdp_datapath.sv
// ---------------------------------------------------------------------------
// mmdp_datapath
// Element stores for A and B, one multiply-accumulate lane and the
// saturating result register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module mmdp_datapath #(
   parameter int DIM = mmdp_pkg::DIM_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  mmdp_pkg::mmdp_cmd_type             cmd,
   input  logic [$clog2(DIM)-1:0]             rd_idx,
   input  logic [mmdp_pkg::IDX_W-1:0]         req_row,
   input  logic [mmdp_pkg::IDX_W-1:0]         req_col,
   input  logic [mmdp_pkg::VAL_W-1:0]         req_value,
   output logic                               pipe_busy,
   output logic [mmdp_pkg::PROD_W-1:0]        product_value,
   output logic [mmdp_pkg::IDX_W-1:0]         row_echo,
   output logic [mmdp_pkg::IDX_W-1:0]         col_echo,
   output logic                               saturated
);
   import mmdp_pkg::*;

   localparam int DEPTH = DIM * DIM;
   localparam int AW    = $clog2(DEPTH);
   localparam int ACC_W = PROD_W + $clog2(DIM) + 1;
   localparam logic [AW-1:0] DIM_A = AW'(DIM);

   logic [VAL_W-1:0]          a_mem [DEPTH];
   logic [VAL_W-1:0]          b_mem [DEPTH];

   logic [IDX_W-1:0]          row_ff, col_ff;
   logic [AW-1:0]             wr_addr, a_addr, b_addr;
   logic                      rd_v_ff, mul_v_ff;
   logic signed [VAL_W-1:0]   a_q_ff, b_q_ff;
   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   logic signed [ACC_W-1:0]   acc_ff, acc_in;
   logic                      fits;
   logic [PROD_W-1:0]         sat_val;
   logic [PROD_W-1:0]         product_ff;
   logic [IDX_W-1:0]          row_echo_ff, col_echo_ff;
   logic                      sat_ff;

   assign wr_addr = AW'(AW'(req_row) * DIM_A + AW'(req_col));
   assign a_addr  = AW'(AW'(row_ff) * DIM_A + AW'(rd_idx));
   assign b_addr  = AW'(AW'(rd_idx) * DIM_A + AW'(col_ff));

   always_ff @(posedge clock) begin
      if (cmd.wr_a) begin
         a_mem[wr_addr] <= req_value;
      end
      if (cmd.wr_b) begin
         b_mem[wr_addr] <= req_value;
      end
      if (cmd.rd) begin
         a_q_ff <= a_mem[a_addr];
         b_q_ff <= b_mem[b_addr];
      end
   end

   assign prod_in = a_q_ff * b_q_ff;
   assign acc_in  = acc_ff + ACC_W'(prod_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_v_ff  <= 1'b0;
         mul_v_ff <= 1'b0;
      end else begin
         rd_v_ff  <= cmd.rd;
         mul_v_ff <= rd_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         row_ff <= req_row;
         col_ff <= req_col;
         acc_ff <= '0;
      end else if (mul_v_ff) begin
         acc_ff <= acc_in;
      end
      if (rd_v_ff) begin
         prod_ff <= prod_in;
      end
   end

   assign pipe_busy = rd_v_ff || mul_v_ff;

   // in range when every bit above bit 63 repeats the sign
   assign fits    = (acc_ff[ACC_W-1:PROD_W-1] == '0) || (acc_ff[ACC_W-1:PROD_W-1] == '1);
   assign sat_val = acc_ff[ACC_W-1] ? {1'b1, {(PROD_W-1){1'b0}}}
                                    : {1'b0, {(PROD_W-1){1'b1}}};

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         product_ff  <= fits ? acc_ff[PROD_W-1:0] : sat_val;
         sat_ff      <= !fits;
         row_echo_ff <= row_ff;
         col_echo_ff <= col_ff;
      end
   end

   assign product_value = product_ff;
   assign row_echo      = row_echo_ff;
   assign col_echo      = col_echo_ff;
   assign saturated     = sat_ff;

   `MMDP_ASSERT_NEXT(a_read_to_mult, cmd.rd, rd_v_ff && mul_v_ff == $past(rd_v_ff),
      "read beat lost before the multiplier")
   `MMDP_ASSERT_IMPL(a_no_load_in_flight, cmd.load, !rd_v_ff && !mul_v_ff,
      "accumulator cleared with pairs in flight")

endmodule

FILE: design/matrix_multiply_dot_product.sv
// Sequence: a product request reads n element pairs (n the size in use clamped
// to DIM, none for an empty sum) through the read, product and accumulator registers.
// Throughput: writes of A or B go one beat per cycle while idle; a request holds
// the input until its result loads, the one multiply-accumulate lane taking one
// pair a cycle, and longer while the previous result waits to be taken.
// Reset: synchronous, active high; clears control and sets the size to 16.
// ---------------------------------------------------------------------------
// matrix_multiply_dot_product
// Dense matrix multiply, one element of C = A * B per request, Q16.16 in,
// saturated Q32.32 out. Element stores are not cleared by reset.
// ---------------------------------------------------------------------------
module matrix_multiply_dot_product #(
   parameter int DIM = mmdp_pkg::DIM_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_wr_en,
   input  logic [mmdp_pkg::SIZE_W-1:0]           csr_wr_data,   // size_in_use
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [mmdp_pkg::REQ_DATA_W-1:0]       req_tdata,     // row, col, element_value
   input  logic [mmdp_pkg::MODE_W-1:0]           req_tuser,     // mode
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [mmdp_pkg::RSP_DATA_W-1:0]       rsp_tdata,     // product_value, row_echo, col_echo
   output logic                                  rsp_tuser      // saturated
);
   import mmdp_pkg::*;

   mmdp_cmd_type              cmd;
   logic [$clog2(DIM)-1:0]    rd_idx;
   logic                      pipe_busy;
   logic [IDX_W-1:0]          req_row, req_col;
   logic [VAL_W-1:0]          req_value;
   logic [PROD_W-1:0]         product_value;
   logic [IDX_W-1:0]          row_echo, col_echo;

   assign req_row   = req_tdata[IDX_W-1:0];
   assign req_col   = req_tdata[2*IDX_W-1:IDX_W];
   assign req_value = req_tdata[2*IDX_W+VAL_W-1:2*IDX_W];

   mmdp_ctrl #(.DIM(DIM)) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_mode    (req_tuser),
      .req_row     (req_row),
      .req_col     (req_col),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .pipe_busy   (pipe_busy),
      .cmd         (cmd),
      .rd_idx      (rd_idx)
   );

   mmdp_datapath #(.DIM(DIM)) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .rd_idx        (rd_idx),
      .req_row       (req_row),
      .req_col       (req_col),
      .req_value     (req_value),
      .pipe_busy     (pipe_busy),
      .product_value (product_value),
      .row_echo      (row_echo),
      .col_echo      (col_echo),
      .saturated     (rsp_tuser)
   );

   assign rsp_tdata = {col_echo, row_echo, product_value};

endmodule
